[rtl/page_frame_bitmap_allocator_macros.svh]
// Assertion helpers shared by the allocator RTL.
// In synthesis builds the macros expand to nothing.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define PFBA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pfba assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define PFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pfba assertion failed: next-cycle implication");

`else

`define PFBA_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define PFBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/pfba_pkg.sv]
package pfba_pkg;

    // Default sizing of the frame pool.
    localparam int PFBA_MAX_FRAMES = 4096;
    localparam int PFBA_PAGE_BYTES = 4096;

    // Bitmap word geometry.
    localparam int WORD_W     = 32;
    localparam int WORD_SHIFT = 5;

    // Request and response field widths.
    localparam int IN_W       = 32;
    localparam int ADDR_OUT_W = 24;
    localparam int CNT_OUT_W  = 13;

    // Command argument: wide enough for a frame count at the largest pool size.
    localparam int ARG_W = 17;

    // Low memory reservations applied by init.
    localparam logic [IN_W-1:0] LOW_RESERVE_BYTES    = 32'h0010_0000;
    localparam logic [IN_W-1:0] KERNEL_RESERVE_BYTES = 32'h0020_0000;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    // Classified command handed from the front end to the back end.
    // For init the argument is the capped frame count, for free the frame index.
    typedef struct packed {
        t_opcode          op;
        logic [ARG_W-1:0] arg;
    } t_cmd;

endpackage

[rtl/pfba_if.sv]
// Request channel: one operation per request.
interface pfba_req_if;
    import pfba_pkg::*;

    logic            valid;
    logic            ready;
    logic [1:0]      opcode;
    logic [IN_W-1:0] mem_bytes;
    logic [IN_W-1:0] free_address;

    modport source (output valid, output opcode, output mem_bytes, output free_address,
                    input ready);
    modport sink   (input valid, input opcode, input mem_bytes, input free_address,
                    output ready);
endinterface

// Response channel: one response per request.
interface pfba_rsp_if;
    import pfba_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ADDR_OUT_W-1:0] alloc_address;
    logic                  alloc_ok;
    logic [CNT_OUT_W-1:0]  free_count;
    logic [CNT_OUT_W-1:0]  usable_count;

    modport source (output valid, output alloc_address, output alloc_ok,
                    output free_count, output usable_count, input ready);
    modport sink   (input valid, input alloc_address, input alloc_ok,
                    input free_count, input usable_count, output ready);
endinterface

[rtl/pfba_ram.sv]
module pfba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/pfba_front.sv]
module pfba_front #(
    parameter int MAX_FRAMES = pfba_pkg::PFBA_MAX_FRAMES,
    parameter int PAGE_BYTES = pfba_pkg::PFBA_PAGE_BYTES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pfba_req_if.sink        i_req,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output pfba_pkg::t_cmd  o_cmd
);
    import pfba_pkg::*;

    localparam int PSHIFT = $clog2(PAGE_BYTES);
    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    logic [IN_W-1:0]   mem_frames;
    logic [IN_W-1:0]   free_frame;
    t_opcode           req_op;
    t_cmd              cls;
    logic              push;
    logic              pop;

    t_cmd              r_q [QDEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0] r_cnt;

    // Classify the request: cap the init frame count, and turn a free beyond
    // the bitmap into a no-op since it can never hit a used frame.
    always_comb begin
        mem_frames = i_req.mem_bytes >> PSHIFT;
        free_frame = i_req.free_address >> PSHIFT;
        req_op     = t_opcode'(i_req.opcode);
        cls.op     = req_op;
        cls.arg    = '0;
        unique case (req_op)
            OP_INIT: begin
                if (mem_frames > IN_W'(MAX_FRAMES)) begin
                    cls.arg = ARG_W'(MAX_FRAMES);
                end else begin
                    cls.arg = ARG_W'(mem_frames);
                end
            end
            OP_FREE: begin
                if (free_frame >= IN_W'(MAX_FRAMES)) begin
                    cls.op = OP_NOP;
                end else begin
                    cls.arg = ARG_W'(free_frame);
                end
            end
            OP_ALLOC: begin
                cls.arg = '0;
            end
            OP_NOP: begin
                cls.arg = '0;
            end
            default: begin
                cls.arg = '0;
            end
        endcase
    end

    // Short command queue that decouples request intake from execution.
    assign i_req.ready = (r_cnt != QCNT_W'(QDEPTH));
    assign push        = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

[rtl/pfba_back.sv]
module pfba_back #(
    parameter int MAX_FRAMES = pfba_pkg::PFBA_MAX_FRAMES,
    parameter int PAGE_BYTES = pfba_pkg::PFBA_PAGE_BYTES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  pfba_pkg::t_cmd i_cmd,
    pfba_rsp_if.source     o_rsp
);
    import pfba_pkg::*;

    localparam int PSHIFT  = $clog2(PAGE_BYTES);
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
    localparam int WORDS   = (MAX_FRAMES + WORD_W - 1) / WORD_W;
    localparam int WADDR_W = $clog2(WORDS);
    localparam int IDX_W   = WADDR_W + WORD_SHIFT;
    localparam int CMP_W   = IDX_W + 1;
    localparam int KRES    = int'(KERNEL_RESERVE_BYTES) / PAGE_BYTES;
    localparam int LRES    = int'(LOW_RESERVE_BYTES) / PAGE_BYTES;
    localparam int KRES_C  = (KRES > MAX_FRAMES) ? MAX_FRAMES : KRES;
    localparam int LRES_C  = (LRES > MAX_FRAMES) ? MAX_FRAMES : LRES;
    localparam logic [WORD_W-1:0] FULL_WORD = '1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INIT = 5'b00010,
        S_SCAN = 5'b00100,
        S_FREE = 5'b01000,
        S_RESP = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_usable, n_usable;
    logic [CNT_W-1:0]       r_used, n_used;
    logic [CNT_W-1:0]       r_reserve, n_reserve;
    logic [WADDR_W-1:0]     r_widx, n_widx;
    logic [WADDR_W-1:0]     r_chk, n_chk;
    logic [WADDR_W:0]       r_nwords, n_nwords;
    logic [WORD_SHIFT-1:0]  r_bit, n_bit;
    logic                   r_ok, n_ok;
    logic [ADDR_OUT_W-1:0]  r_addr, n_addr;
    logic                   r_ovalid, n_ovalid;
    logic [ADDR_OUT_W-1:0]  r_o_addr, n_o_addr;
    logic                   r_o_ok, n_o_ok;
    logic [CNT_OUT_W-1:0]   r_o_free, n_o_free;
    logic [CNT_OUT_W-1:0]   r_o_usable, n_o_usable;

    logic                   ram_we;
    logic [WADDR_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic [WADDR_W-1:0]     ram_raddr;
    logic [WORD_W-1:0]      ram_rdata;

    logic [CNT_W-1:0]       cmd_n;
    logic [IDX_W-1:0]       cmd_fidx;
    logic [CNT_W-1:0]       rsv;
    logic [WADDR_W:0]       usable_words;
    logic [WORD_W-1:0]      init_word;
    logic [WORD_SHIFT-1:0]  hit_bit;
    logic [ADDR_OUT_W+IDX_W+PSHIFT-1:0] hit_wide;
    logic [CNT_W-1:0]       free_cnt;
    logic [CNT_W+CNT_OUT_W-1:0] free_wide;
    logic [CNT_W+CNT_OUT_W-1:0] usable_wide;
    logic                   scan_last;
    logic                   rsp_take;

    // Bitmap storage, one bit per frame, set when the frame is in use.
    pfba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Command decoding: init frame count, its reservation and the free index.
    assign cmd_n        = CNT_W'(i_cmd.arg);
    assign cmd_fidx     = IDX_W'(i_cmd.arg);
    assign rsv          = (IN_W'(KRES) > IN_W'(cmd_n)) ? CNT_W'(LRES_C) : CNT_W'(KRES_C);
    assign usable_words = (WADDR_W + 1)'(r_usable >> WORD_SHIFT);

    // Word written during the init sweep: ones below the reserved count.
    always_comb begin
        for (int j = 0; j < WORD_W; j++) begin
            init_word[j] = CMP_W'({r_widx, WORD_SHIFT'(j)}) < CMP_W'(r_reserve);
        end
    end

    // Lowest clear bit of the word under inspection.
    always_comb begin
        hit_bit = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (!ram_rdata[j]) begin
                hit_bit = WORD_SHIFT'(j);
            end
        end
    end

    assign hit_wide  = {{ADDR_OUT_W{1'b0}}, r_chk, hit_bit, {PSHIFT{1'b0}}};
    assign scan_last = (({1'b0, r_chk} + 1'b1) == r_nwords);

    // Response counts, with the free count held at zero instead of wrapping.
    assign free_cnt    = (r_usable > r_used) ? (r_usable - r_used) : '0;
    assign free_wide   = {{CNT_OUT_W{1'b0}}, free_cnt};
    assign usable_wide = {{CNT_OUT_W{1'b0}}, r_usable};

    assign rsp_take    = !r_ovalid || o_rsp.ready;
    assign o_cmd_ready = (r_state == S_IDLE);

    // Execution sequencer.
    always_comb begin
        n_state    = r_state;
        n_usable   = r_usable;
        n_used     = r_used;
        n_reserve  = r_reserve;
        n_widx     = r_widx;
        n_chk      = r_chk;
        n_nwords   = r_nwords;
        n_bit      = r_bit;
        n_ok       = r_ok;
        n_addr     = r_addr;
        n_ovalid   = r_ovalid;
        n_o_addr   = r_o_addr;
        n_o_ok     = r_o_ok;
        n_o_free   = r_o_free;
        n_o_usable = r_o_usable;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_raddr  = '0;

        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_ok   = 1'b0;
                    n_addr = '0;
                    unique case (i_cmd.op)
                        OP_INIT: begin
                            n_usable  = cmd_n;
                            n_used    = rsv;
                            n_reserve = rsv;
                            n_widx    = '0;
                            n_state   = S_INIT;
                        end
                        OP_ALLOC: begin
                            n_nwords  = usable_words;
                            n_chk     = '0;
                            ram_raddr = '0;
                            n_state   = (usable_words == '0) ? S_RESP : S_SCAN;
                        end
                        OP_FREE: begin
                            n_chk     = cmd_fidx[IDX_W-1:WORD_SHIFT];
                            n_bit     = cmd_fidx[WORD_SHIFT-1:0];
                            ram_raddr = cmd_fidx[IDX_W-1:WORD_SHIFT];
                            if (CMP_W'(cmd_fidx) < CMP_W'(r_usable)) begin
                                n_state = S_FREE;
                            end else begin
                                n_state = S_RESP;
                            end
                        end
                        OP_NOP: begin
                            n_state = S_RESP;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_INIT: begin
                // Rewrite every bitmap word, one per cycle.
                ram_we    = 1'b1;
                ram_waddr = r_widx;
                ram_wdata = init_word;
                n_widx    = r_widx + 1'b1;
                if (r_widx == WADDR_W'(WORDS - 1)) begin
                    n_state = S_RESP;
                end
            end
            S_SCAN: begin
                // The read of the next word is issued while this one is checked.
                if (ram_rdata != FULL_WORD) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_chk;
                    ram_wdata = ram_rdata | (WORD_W'(1) << hit_bit);
                    n_used    = r_used + 1'b1;
                    n_ok      = 1'b1;
                    n_addr    = hit_wide[ADDR_OUT_W-1:0];
                    n_state   = S_RESP;
                end else if (scan_last) begin
                    n_state = S_RESP;
                end else begin
                    n_chk     = r_chk + 1'b1;
                    ram_raddr = r_chk + 1'b1;
                end
            end
            S_FREE: begin
                if (ram_rdata[r_bit]) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_chk;
                    ram_wdata = ram_rdata & ~(WORD_W'(1) << r_bit);
                    if (r_used != '0) begin
                        n_used = r_used - 1'b1;
                    end
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (rsp_take) begin
                    n_ovalid   = 1'b1;
                    n_o_addr   = r_addr;
                    n_o_ok     = r_ok;
                    n_o_free   = free_wide[CNT_OUT_W-1:0];
                    n_o_usable = usable_wide[CNT_OUT_W-1:0];
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and pool state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_usable <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_usable <= n_usable;
            r_used   <= n_used;
            r_ovalid <= n_ovalid;
        end
    end

    // Working and response payload.
    always_ff @(posedge i_clk) begin
        r_reserve  <= n_reserve;
        r_widx     <= n_widx;
        r_chk      <= n_chk;
        r_nwords   <= n_nwords;
        r_bit      <= n_bit;
        r_ok       <= n_ok;
        r_addr     <= n_addr;
        r_o_addr   <= n_o_addr;
        r_o_ok     <= n_o_ok;
        r_o_free   <= n_o_free;
        r_o_usable <= n_o_usable;
    end

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.alloc_address = r_o_addr;
    assign o_rsp.alloc_ok      = r_o_ok;
    assign o_rsp.free_count    = r_o_free;
    assign o_rsp.usable_count  = r_o_usable;
endmodule

[rtl/page_frame_bitmap_allocator.sv]
// First-fit page frame allocator with one bitmap bit per frame, kept in a
// (MAX_FRAMES/32)-word RAM. Every request returns exactly one response that
// carries the free and usable frame counts. Requests enter a two-entry command
// queue, so intake continues while a request executes or a response waits.
// The bitmap RAM, with one write port and one registered read port, handles
// one word per cycle: init rewrites every bitmap word, allocate inspects words
// in order until it finds a clear bit or passes the last usable word, and free
// reads the frame's word and clears its bit unless the frame lies outside the
// pool. Allocate searches only whole 32-frame words below the usable count.
// The bitmap is not cleared after reset: nothing reads it before the first
// init, which rewrites every word. PAGE_BYTES must be a power of two.
`include "page_frame_bitmap_allocator_macros.svh"

module page_frame_bitmap_allocator #(
    parameter int MAX_FRAMES = pfba_pkg::PFBA_MAX_FRAMES,
    parameter int PAGE_BYTES = pfba_pkg::PFBA_PAGE_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pfba_req_if.sink   i_req,
    pfba_rsp_if.source o_rsp
);
    import pfba_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    // Request intake, classification and command queue.
    pfba_front #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // Bitmap sequencer and response register.
    pfba_back #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_rsp       (o_rsp)
    );

    // A command taken by the back end leaves it busy in the next cycle.
    `PFBA_ASSERT_NEXT(a_cmd_pop_busy, i_clk, i_rst_n, cmd_valid && cmd_ready, !cmd_ready)
    // A response without a granted frame carries address zero.
    `PFBA_ASSERT_IMPLIES(a_fail_addr_zero, i_clk, i_rst_n, o_rsp.valid && !o_rsp.alloc_ok, o_rsp.alloc_address == '0)
endmodule
